>>> rtl/hsv_pkg.sv
// Shared constants, codes and types of the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv_pkg;

    // Channel precision: full scale (2^CHANNEL_BITS - 1) stands for 1.0.
    localparam int CHANNEL_BITS = 8;
    localparam int CW           = CHANNEL_BITS;

    // Fixed field widths of the stream items.
    localparam int HUE_W       = 9;
    localparam int SAT_W       = 8;
    localparam int BRI_W       = 8;
    localparam int OUT_W       = 8;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // Bit offsets inside s_axis_tdata.
    localparam int HUE_LSB = 0;
    localparam int SAT_LSB = HUE_LSB + HUE_W;
    localparam int BRI_LSB = SAT_LSB + SAT_W;

    localparam logic [HUE_W-1:0] HUE_WRAP = HUE_W'(360);

    // Secondary weight 60 - |hue mod 120 - 60| spans 0..60.
    localparam int WT_W = 6;
    localparam int Y_W  = CW + WT_W;

    // floor(y / 60) as (y * RECIP_MUL) >> RECIP_SHIFT, exact for y < 2^Y_W.
    localparam int              RECIP_SHIFT = CW + 12;
    localparam int              RM_W        = CW + 7;
    localparam longint unsigned RECIP_MUL_L =
        ((64'd1 << RECIP_SHIFT) + 64'd59) / 64'd60;
    localparam logic [RM_W-1:0] RECIP_MUL   = RM_W'(RECIP_MUL_L);
    localparam int              Z_W         = Y_W + RM_W;

    // Queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Hue sectors, 60 degrees each.
    typedef logic [2:0] t_sector;
    localparam t_sector SEC_RY = 3'd0;   // red to yellow:    (C, X, 0)
    localparam t_sector SEC_YG = 3'd1;   // yellow to green:  (X, C, 0)
    localparam t_sector SEC_GC = 3'd2;   // green to cyan:    (0, C, X)
    localparam t_sector SEC_CB = 3'd3;   // cyan to blue:     (0, X, C)
    localparam t_sector SEC_BM = 3'd4;   // blue to magenta:  (X, 0, C)
    localparam t_sector SEC_MR = 3'd5;   // magenta to red:   (C, 0, X)

    // Classified pixel, handed from the front part to the back part.
    typedef struct packed {
        t_sector         sector;
        logic [WT_W-1:0] weight;
        logic [CW-1:0]   sat;
        logic [CW-1:0]   val;
    } t_cls;

    // Result pixel; red sits in the lowest bits.
    typedef struct packed {
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] red;
    } t_rgb;

    // Queue status seen by the top level.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [QCNT_W-1:0] cnt;
    } t_q_stat;

endpackage

>>> rtl/hsv_to_rgb_converter_unit.sv
// Top level of the HSV to RGB pixel converter.
`timescale 1ns / 1ps

// Converts one pixel per item from hue (degrees, 0..511, 360 and above wrap
// once by 360) with 8-bit saturation and value, where full scale stands for
// 1.0, into 8-bit red, green and blue, truncating at every division. The
// block sustains one pixel per clock: a new item is taken every cycle as long
// as results are taken. Between the accepting edge and the result showing
// valid, each item passes through the front classification register, the
// queue and the four-stage back pipeline (product, chroma and weighted
// product, reciprocal multiply for the division by 60, placement). The
// four-item queue sits between the front and back parts, so a stall at the
// output first fills the back pipeline and the queue before s_axis_tready
// drops. The block has no configuration and no state across items.

module hsv_to_rgb_converter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // hue[8:0], saturation[16:9], brightness[24:17], zero fill [31:25]
    input  logic [hsv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [hsv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import hsv_pkg::*;

    logic             f_valid;
    logic             f_ready;
    t_cls             f_cls;
    logic             q_valid;
    logic             q_ready;
    t_cls             q_cls;
    t_q_stat          q_stat;
    t_rgb             b_rgb;
    logic [HUE_W-1:0] in_hue;
    logic [SAT_W-1:0] in_sat;
    logic [BRI_W-1:0] in_bri;

    // Unpack the input item.
    assign in_hue = s_axis_tdata[HUE_LSB +: HUE_W];
    assign in_sat = s_axis_tdata[SAT_LSB +: SAT_W];
    assign in_bri = s_axis_tdata[BRI_LSB +: BRI_W];

    // Front: wrap hue, pick the sector and the secondary weight.
    hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_hue   (in_hue),
        .i_sat   (in_sat),
        .i_bri   (in_bri),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cls   (f_cls)
    );

    // Queue: let front and back stall on their own.
    hsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cls   (f_cls),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cls   (q_cls),
        .o_stat  (q_stat)
    );

    // Back: arithmetic pipeline ending in the output register.
    hsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cls   (q_cls),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rgb   (b_rgb)
    );

    assign m_axis_tdata = OUT_TDATA_W'(b_rgb);

    // Never push into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.push |-> (q_stat.cnt != QCNT_W'(QDEPTH)))
        else $error("queue push while full");

    // Never pop an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.pop |-> (q_stat.cnt != '0))
        else $error("queue pop while empty");

    // Fill count follows pushes and pops exactly.
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.push || q_stat.pop || (q_stat.cnt == q_stat.cnt) |=>
        (q_stat.cnt == $past(q_stat.cnt) + QCNT_W'($past(q_stat.push))
                       - QCNT_W'($past(q_stat.pop))))
        else $error("queue count out of step");

    // A waiting queue entry moves on whenever the back part can take it.
    a_pop_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.cnt != '0) && q_ready |-> q_stat.pop)
        else $error("queue entry held while back part ready");

endmodule

>>> rtl/hsv_front.sv
// Front part: accept a pixel, wrap the hue, find its sector and secondary weight.
`timescale 1ns / 1ps

module hsv_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [hsv_pkg::HUE_W-1:0] i_hue,
    input  logic [hsv_pkg::SAT_W-1:0] i_sat,
    input  logic [hsv_pkg::BRI_W-1:0] i_bri,
    output logic                      o_valid,
    input  logic                      i_ready,
    output hsv_pkg::t_cls             o_cls
);
    import hsv_pkg::*;

    logic             r_valid;
    t_cls             r_cls;
    t_cls             n_cls;
    logic [HUE_W-1:0] hue_w;
    logic [1:0]       pair;
    logic [6:0]       hue_rem;
    logic             upper;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_comb begin
        hue_w = (i_hue >= HUE_WRAP) ? (i_hue - HUE_WRAP) : i_hue;
        if (hue_w < HUE_W'(120)) begin
            pair    = 2'd0;
            hue_rem = 7'(hue_w);
        end else if (hue_w < HUE_W'(240)) begin
            pair    = 2'd1;
            hue_rem = 7'(hue_w - HUE_W'(120));
        end else begin
            pair    = 2'd2;
            hue_rem = 7'(hue_w - HUE_W'(240));
        end
        upper          = (hue_rem >= 7'd60);
        n_cls.sector   = t_sector'({pair, upper});
        n_cls.weight   = upper ? WT_W'(7'd120 - hue_rem) : WT_W'(hue_rem);
        n_cls.sat      = CW'(i_sat);
        n_cls.val      = CW'(i_bri);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule

>>> rtl/hsv_queue.sv
// Short queue of classified pixels between the front and back parts.
`timescale 1ns / 1ps

module hsv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hsv_pkg::t_cls    i_cls,
    output logic             o_valid,
    input  logic             i_ready,
    output hsv_pkg::t_cls    o_cls,
    output hsv_pkg::t_q_stat o_stat
);
    import hsv_pkg::*;

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign n_cnt   = r_cnt + QCNT_W'(push) - QCNT_W'(pop);

    assign o_stat.push = push;
    assign o_stat.pop  = pop;
    assign o_stat.cnt  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

>>> rtl/hsv_back.sv
// Back part: chroma, secondary component, sector placement and offset, four stages.
`timescale 1ns / 1ps

module hsv_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hsv_pkg::t_cls i_cls,
    output logic          o_valid,
    input  logic          i_ready,
    output hsv_pkg::t_rgb o_rgb
);
    import hsv_pkg::*;

    // Stage 1: value times saturation.
    logic              r_v1;
    logic [2*CW-1:0]   r_p1;
    t_sector           r_sec1;
    logic [WT_W-1:0]   r_wt1;
    logic [CW-1:0]     r_val1;
    logic [2*CW-1:0]   n_p1;
    // Stage 2: chroma and chroma times weight.
    logic              r_v2;
    logic [CW-1:0]     r_c2;
    logic [Y_W-1:0]    r_y2;
    t_sector           r_sec2;
    logic [CW-1:0]     r_val2;
    logic [2*CW:0]     c_sum;
    logic [CW-1:0]     n_c2;
    logic [Y_W-1:0]    n_y2;
    // Stage 3: divide by 60 through the reciprocal.
    logic              r_v3;
    logic [Z_W-1:0]    r_z3;
    logic [CW-1:0]     r_c3;
    t_sector           r_sec3;
    logic [CW-1:0]     r_val3;
    logic [Z_W-1:0]    n_z3;
    // Stage 4: placement and offset into the output register.
    logic              r_v4;
    t_rgb              r_rgb;
    t_rgb              n_rgb;
    logic [CW-1:0]     x4;
    logic [CW-1:0]     m4;
    logic [CW-1:0]     rr;
    logic [CW-1:0]     gg;
    logic [CW-1:0]     bb;
    logic [CW:0]       red_sum;
    logic [CW:0]       g_sum;
    logic [CW:0]       b_sum;

    logic en1;
    logic en2;
    logic en3;
    logic en4;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v4;
    assign o_rgb   = r_rgb;

    assign n_p1 = (2*CW)'(i_cls.val) * (2*CW)'(i_cls.sat);

    // floor(p / (2^CW - 1)) = (p + (p >> CW) + 1) >> CW over the product range.
    assign c_sum = (2*CW+1)'(r_p1) + (2*CW+1)'(r_p1 >> CW) + (2*CW+1)'(1);
    assign n_c2  = CW'(c_sum >> CW);
    assign n_y2  = Y_W'(n_c2) * Y_W'(r_wt1);

    assign n_z3 = Z_W'(r_y2) * Z_W'(RECIP_MUL);

    always_comb begin
        x4 = CW'(r_z3 >> RECIP_SHIFT);
        m4 = r_val3 - r_c3;
        unique case (r_sec3)
            SEC_RY: begin rr = r_c3; gg = x4;   bb = '0;   end
            SEC_YG: begin rr = x4;   gg = r_c3; bb = '0;   end
            SEC_GC: begin rr = '0;   gg = r_c3; bb = x4;   end
            SEC_CB: begin rr = '0;   gg = x4;   bb = r_c3; end
            SEC_BM: begin rr = x4;   gg = '0;   bb = r_c3; end
            default: begin rr = r_c3; gg = '0;  bb = x4;   end
        endcase
        red_sum     = (CW+1)'(rr) + (CW+1)'(m4);
        g_sum       = (CW+1)'(gg) + (CW+1)'(m4);
        b_sum       = (CW+1)'(bb) + (CW+1)'(m4);
        n_rgb.red   = OUT_W'(red_sum[CW-1:0]);
        n_rgb.green = OUT_W'(g_sum[CW-1:0]);
        n_rgb.blue  = OUT_W'(b_sum[CW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_p1   <= n_p1;
            r_sec1 <= i_cls.sector;
            r_wt1  <= i_cls.weight;
            r_val1 <= i_cls.val;
        end
        if (en2 && r_v1) begin
            r_c2   <= n_c2;
            r_y2   <= n_y2;
            r_sec2 <= r_sec1;
            r_val2 <= r_val1;
        end
        if (en3 && r_v2) begin
            r_z3   <= n_z3;
            r_c3   <= r_c2;
            r_sec3 <= r_sec2;
            r_val3 <= r_val2;
        end
        if (en4 && r_v3) begin
            r_rgb <= n_rgb;
        end
    end

endmodule

>>> test/testbench.sv
// Self-checking stream testbench for the HSV to RGB pixel converter.
`timescale 1ns / 1ps

module testbench;
    import hsv_pkg::*;

    localparam int RANDOM_PER_PHASE = 670;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int FULL_SCALE       = (1 << CHANNEL_BITS) - 1;

    // Expected pixels in arrival order, with a mismatch count.
    class pixel_scoreboard;
        t_rgb        expected_q[$];
        int unsigned mismatch_cnt = 0;

        function t_rgb predict_rgb(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                   logic [BRI_W-1:0] bri);
            int unsigned h, chroma, second, offset, hue_rem, distance, rr, gg, bb;
            t_rgb        pix;
            h = 32'(hue);
            // hue of 360 and above wraps once
            if (h >= 360)
                h -= 360;
            chroma   = (32'(bri) * 32'(sat)) / FULL_SCALE;
            hue_rem  = h % 120;
            distance = (hue_rem >= 60) ? hue_rem - 60 : 60 - hue_rem;
            second   = (chroma * (60 - distance)) / 60;
            offset   = 32'(bri) - chroma;
            case (t_sector'(h / 60))
                SEC_RY: begin rr = chroma; gg = second; bb = 0;      end
                SEC_YG: begin rr = second; gg = chroma; bb = 0;      end
                SEC_GC: begin rr = 0;      gg = chroma; bb = second; end
                SEC_CB: begin rr = 0;      gg = second; bb = chroma; end
                SEC_BM: begin rr = second; gg = 0;      bb = chroma; end
                default: begin rr = chroma; gg = 0;     bb = second; end
            endcase
            pix.red   = OUT_W'(rr + offset);
            pix.green = OUT_W'(gg + offset);
            pix.blue  = OUT_W'(bb + offset);
            return pix;
        endfunction

        function void note_pixel(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                 logic [BRI_W-1:0] bri);
            expected_q.push_back(predict_rgb(hue, sat, bri));
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("ERROR at %0t: %s got %0d, want %0d", $realtime, what, got, want);
            mismatch_cnt++;
        endtask

        task check_pixel(t_rgb got);
            t_rgb want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected pixel, red", got.red, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.red !== want.red)
                    report_mismatch("red", got.red, want.red);
                if (got.green !== want.green)
                    report_mismatch("green", got.green, want.green);
                if (got.blue !== want.blue)
                    report_mismatch("blue", got.blue, want.blue);
            end
        endtask
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int unsigned     sender_gap_pct     = 0;
    int unsigned     receiver_stall_pct = 0;
    int unsigned     quiet_cycles       = 0;
    pixel_scoreboard sb                 = new;

    hsv_to_rgb_converter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Output side stalls at random.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Note accepted items, check accepted pixels, and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pixel(s_axis_tdata[HUE_LSB +: HUE_W],
                              s_axis_tdata[SAT_LSB +: SAT_W],
                              s_axis_tdata[BRI_LSB +: BRI_W]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pixel(t_rgb'(m_axis_tdata));
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Hold the item until accepted; idle before it at random.
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                              input logic [BRI_W-1:0] bri);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({bri, sat, hue});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Favor zero and full scale now and then.
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'(FULL_SCALE);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_pixels(input int count);
        logic [HUE_W-1:0] hue;
        for (int i = 0; i < count; i++) begin
            // mostly legal hues, some in the wrapping range 360..511
            if ($urandom_range(0, 7) == 0)
                hue = HUE_W'($urandom_range(360, 511));
            else
                hue = HUE_W'($urandom_range(0, 359));
            send_pixel(hue, pick_channel(), pick_channel());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_gap_pct     = 6;
        receiver_stall_pct = 73;

        // Sector edges at full scale, the wrap at 360 and above, flat and dark pixels, and mixed mid-range pixels.
        send_pixel(9'd0,   8'd255, 8'd255);
        send_pixel(9'd59,  8'd255, 8'd255);
        send_pixel(9'd60,  8'd255, 8'd255);
        send_pixel(9'd119, 8'd255, 8'd255);
        send_pixel(9'd120, 8'd255, 8'd255);
        send_pixel(9'd179, 8'd255, 8'd255);
        send_pixel(9'd180, 8'd255, 8'd255);
        send_pixel(9'd239, 8'd255, 8'd255);
        send_pixel(9'd240, 8'd255, 8'd255);
        send_pixel(9'd299, 8'd255, 8'd255);
        send_pixel(9'd300, 8'd255, 8'd255);
        send_pixel(9'd359, 8'd255, 8'd255);
        send_pixel(9'd360, 8'd255, 8'd255);
        send_pixel(9'd361, 8'd200, 8'd180);
        send_pixel(9'd420, 8'd255, 8'd255);
        send_pixel(9'd511, 8'd255, 8'd255);
        send_pixel(9'd30,  8'd0,   8'd255);
        send_pixel(9'd90,  8'd255, 8'd0);
        send_pixel(9'd210, 8'd0,   8'd0);
        send_pixel(9'd150, 8'd128, 8'd200);
        send_pixel(9'd270, 8'd1,   8'd254);
        send_pixel(9'd330, 8'd254, 8'd1);
        send_pixel(9'd45,  8'd170, 8'd85);

        send_random_pixels(RANDOM_PER_PHASE);

        sender_gap_pct     = 73;
        receiver_stall_pct = 6;
        send_random_pixels(RANDOM_PER_PHASE);

        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        send_random_pixels(RANDOM_PER_PHASE);

        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
rtl/hsv_pkg.sv
rtl/hsv_front.sv
rtl/hsv_queue.sv
rtl/hsv_back.sv
rtl/hsv_to_rgb_converter_unit.sv
test/testbench.sv
